/* hw/rtl/gtve_pkg.sv */
// Package for the GPRS timer value encoder.
// Holds timer kind, status codes, unit tables and controller/datapath types.
// No dependencies.
`timescale 1ns / 1ps

package gtve_pkg;

    localparam int SecsW = 32;
    localparam int UnitW = 21;
    localparam int BestW = 22;
    localparam int CntW  = 5;

    localparam logic [1:0] KIND_RAU    = 2'd0;
    localparam logic [1:0] KIND_READY  = 2'd1;
    localparam logic [1:0] KIND_ACTIVE = 2'd2;
    localparam logic [1:0] KIND_TAU    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;

    localparam logic [SecsW-1:0] ActiveLimit = 32'd11160;
    localparam logic [SecsW-1:0] TauLimit    = 32'd2592000;
    localparam logic [BestW-1:0] RemBound    = 22'd2592000;
    localparam logic [7:0]       DeactCode   = 8'hE0;
    localparam logic [2:0]       LastUnit    = 3'd6;
    localparam logic [2:0]       TopBit      = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_UNIT,
        S_DIV,
        S_EVAL,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic init_unit;
        logic div_step;
        logic eval;
        logic next_unit;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic limit_hit;
        logic secs_zero;
        logic unit_usable;
        logic last_unit;
        logic last_bit;
        logic out_full;
    } dp_stat_t;

    // Seconds per unit, zero where the unit code is unused for the kind.
    function automatic logic [UnitW-1:0] unit_value(input logic [1:0] kind,
                                                    input logic [2:0] code);
        logic [UnitW-1:0] v;
        v = '0;
        case (code)
            3'd0: v = 21'd600;
            3'd1: v = 21'd3600;
            3'd2: v = 21'd36000;
            3'd3: v = 21'd2;
            3'd4: v = 21'd30;
            3'd5: v = 21'd60;
            3'd6: v = 21'd1152000;
            default: v = '0;
        endcase
        case (kind)
            KIND_READY, KIND_ACTIVE:
            begin
                case (code)
                    3'd0: v = 21'd2;
                    3'd1: v = 21'd60;
                    3'd2: v = 21'd360;
                    default: v = '0;
                endcase
            end
            KIND_RAU:
            begin
                if (code == 3'd6)
                begin
                    v = '0;
                end
            end
            default: ;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/gtve_ctrl.sv */
// Controller FSM of the GPRS timer value encoder.
// Sequences limit check, per-unit division and result load; uses gtve_pkg.
`timescale 1ns / 1ps

module gtve_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  gtve_pkg::dp_stat_t stat,
    output gtve_pkg::ctl_cmd_t cmd
);
    import gtve_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.limit_hit || stat.secs_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_UNIT;
                end
            end
            S_UNIT:
            begin
                if (stat.unit_usable)
                begin
                    state_next = S_DIV;
                end
                else if (stat.last_unit)
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIV:
            begin
                if (stat.last_bit)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.last_unit)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_UNIT;
                end
            end
            S_FINISH:
            begin
                if (!stat.out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_UNIT:
            begin
                cmd.init_unit = stat.unit_usable;
                cmd.next_unit = !stat.unit_usable && !stat.last_unit;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_EVAL:
            begin
                cmd.eval      = 1'b1;
                cmd.next_unit = !stat.last_unit;
            end
            S_FINISH:
            begin
                cmd.out_load = !stat.out_full;
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/gtve_datapath.sv */
// Datapath of the GPRS timer value encoder: operand registers, 5-step
// restoring divider, best-unit tracking and output register; uses gtve_pkg.
`timescale 1ns / 1ps

module gtve_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         in_kind,
    input  logic [31:0]        in_secs,
    input  gtve_pkg::ctl_cmd_t cmd,
    output gtve_pkg::dp_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_status,
    output logic [7:0]         out_byte
);
    import gtve_pkg::*;

    logic [1:0]       kind_reg;
    logic [SecsW-1:0] secs_reg;
    logic [2:0]       u_reg;
    logic [2:0]       bit_reg;
    logic [SecsW-1:0] rem_reg;
    logic [CntW-1:0]  q_reg;
    logic [BestW-1:0] best_rem_reg;
    logic [2:0]       best_code_reg;
    logic [CntW-1:0]  best_cnt_reg;
    logic             found_reg;
    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic [7:0]       byte_reg;

    logic [UnitW-1:0] unit;
    logic [SecsW:0]   unit_x32;
    logic [SecsW-1:0] unit_sh;
    logic [BestW-1:0] rem_now;
    logic [1:0]       status_next;
    logic [7:0]       byte_next;

    assign unit     = unit_value(kind_reg, u_reg);
    assign unit_x32 = (SecsW + 1)'(unit) << CntW;
    assign unit_sh  = SecsW'(unit) << bit_reg;
    assign rem_now  = BestW'(rem_reg[UnitW-1:0]);

    assign stat.limit_hit   = ((kind_reg == KIND_ACTIVE) && (secs_reg > ActiveLimit))
                            || ((kind_reg == KIND_TAU) && (secs_reg > TauLimit));
    assign stat.secs_zero   = (secs_reg == '0);
    assign stat.unit_usable = (unit != '0) && (secs_reg >= SecsW'(unit))
                            && ({1'b0, secs_reg} < unit_x32);
    assign stat.last_unit   = (u_reg == LastUnit);
    assign stat.last_bit    = (bit_reg == '0);
    assign stat.out_full    = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg     <= in_kind;
            secs_reg     <= in_secs;
            u_reg        <= '0;
            best_rem_reg <= RemBound;
            found_reg    <= 1'b0;
        end
        if (cmd.next_unit)
        begin
            u_reg <= u_reg + 3'd1;
        end
        if (cmd.init_unit)
        begin
            rem_reg <= secs_reg;
            q_reg   <= '0;
            bit_reg <= TopBit;
        end
        if (cmd.div_step)
        begin
            if (rem_reg >= unit_sh)
            begin
                rem_reg <= rem_reg - unit_sh;
                q_reg   <= q_reg | (CntW'(1) << bit_reg);
            end
            bit_reg <= bit_reg - 3'd1;
        end
        if (cmd.eval && (rem_now < best_rem_reg))
        begin
            best_rem_reg  <= rem_now;
            best_code_reg <= u_reg;
            best_cnt_reg  <= q_reg;
            found_reg     <= 1'b1;
        end
        if (cmd.out_load)
        begin
            status_reg <= status_next;
            byte_reg   <= byte_next;
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        byte_next   = '0;
        if (stat.limit_hit)
        begin
            status_next = ST_LIMIT;
        end
        else if (stat.secs_zero)
        begin
            byte_next = DeactCode;
        end
        else if (found_reg)
        begin
            byte_next = {best_code_reg, best_cnt_reg};
        end
        else
        begin
            status_next = ST_NOFIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_byte   = byte_reg;

`ifndef SYNTHESIS
    a_byte_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != ST_OK) |-> (byte_reg == '0))
        else $error("timer byte not zero on error status");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> (q_reg != '0))
        else $error("usable unit produced zero count");

    a_rem_below_unit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> (rem_reg < SecsW'(unit)))
        else $error("division remainder not below unit");

    a_load_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("result loaded over pending beat");
`endif

endmodule

/* hw/rtl/gprs_timer_value_encoder_core.sv */
// GPRS timer value encoder top level: controller plus datapath.
// Per input beat: limit check, then each unit in turn (a usable unit runs the 5-step
// divider; at most three units are usable), then the result load, held by output stalls.
// One item in flight at a time.
// Input is taken again once the result sits in the output register.
// Reset rst_n is asynchronous, active low, and clears control state only.
`timescale 1ns / 1ps

module gprs_timer_value_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] seconds
    input  logic [1:0]  s_axis_tuser,   // [1:0] timer_kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] timer_byte
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import gtve_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    gtve_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gtve_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_kind    (s_axis_tuser),
        .in_secs    (s_axis_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_byte   (m_axis_tdata)
    );

endmodule

/* test/gprs_timer_value_encoder_core_test.sv */
// Testbench for gprs_timer_value_encoder_core: directed and random timer encodings
// checked beat by beat against a local encoder predictor.
// Depends on gtve_pkg and the core RTL.
`timescale 1ns / 1ps

module gprs_timer_value_encoder_core_test;
    import gtve_pkg::*;

    localparam int unsigned MAX_COUNT        = 31;
    localparam int unsigned ACTIVE_MAX_SECS  = 11160;
    localparam int unsigned TAU_MAX_SECS     = 2592000;
    localparam int unsigned REM_CEILING      = 2592000;
    localparam logic [7:0]  DEACTIVATED_BYTE = 8'hE0;
    localparam int          DRAIN_CYCLES     = 80;
    localparam int          MAX_REPORTS      = 10;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] timer_byte;
    } timer_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    timer_result_t expected_codes[$];
    int            mismatch_count = 0;
    int            src_idle_pct = 12;
    int            sink_idle_pct = 48;

    gprs_timer_value_encoder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned unit_secs(input logic [1:0] kind,
                                                  input logic [2:0] code);
        longint unsigned len;
        len = 0;
        case (kind)
            KIND_READY, KIND_ACTIVE:
            begin
                case (code)
                    3'd0: len = 2;
                    3'd1: len = 60;
                    3'd2: len = 360;
                    default: len = 0;
                endcase
            end
            default:
            begin
                case (code)
                    3'd0: len = 600;
                    3'd1: len = 3600;
                    3'd2: len = 36000;
                    3'd3: len = 2;
                    3'd4: len = 30;
                    3'd5: len = 60;
                    3'd6: len = (kind == KIND_TAU) ? 1152000 : 0;
                    default: len = 0;
                endcase
            end
        endcase
        return len;
    endfunction

    function automatic timer_result_t predict_timer_code(input logic [1:0] kind,
                                                         input logic [31:0] secs);
        timer_result_t   r;
        longint unsigned unit_len;
        longint unsigned cnt;
        longint unsigned rem;
        longint unsigned best_rem;
        logic [2:0]      best_code;
        logic [4:0]      best_cnt;
        bit              found;
        r.status = ST_OK;
        r.timer_byte = '0;
        if ((kind == KIND_ACTIVE && secs > ACTIVE_MAX_SECS) ||
            (kind == KIND_TAU && secs > TAU_MAX_SECS))
        begin
            r.status = ST_LIMIT;
            return r;
        end
        if (secs == 0)
        begin
            r.timer_byte = DEACTIVATED_BYTE;
            return r;
        end
        best_rem = 64'(REM_CEILING);
        best_code = '0;
        best_cnt = '0;
        found = 1'b0;
        for (int code = 0; code < 8; code++)
        begin
            unit_len = unit_secs(kind, code[2:0]);
            if (unit_len == 0)
                continue;
            cnt = 64'(secs) / unit_len;
            if (cnt < 64'd1 || cnt > 64'(MAX_COUNT))
                continue;
            rem = 64'(secs) - cnt * unit_len;
            // strict compare: lowest code wins a tie
            if (rem < best_rem)
            begin
                best_rem = rem;
                best_code = code[2:0];
                best_cnt = cnt[4:0];
                found = 1'b1;
            end
        end
        if (!found)
            r.status = ST_NOFIT;
        else
            r.timer_byte = {best_code, best_cnt};
        return r;
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [31:0] secs);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= secs;
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_codes.push_back(predict_timer_code(kind, secs));
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

    always @(posedge clk)
    begin
        timer_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_codes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected beat: status %0d byte %02h",
                             m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want = expected_codes.pop_front();
                if (m_axis_tuser !== want.status || m_axis_tdata !== want.timer_byte)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: status exp %0d got %0d, byte exp %02h got %02h",
                                 want.status, m_axis_tuser, want.timer_byte, m_axis_tdata);
                end
            end
        end
    end

    task automatic check_deactivate();
        send_request(KIND_RAU, 32'd0);
        send_request(KIND_READY, 32'd0);
        send_request(KIND_ACTIVE, 32'd0);
        send_request(KIND_TAU, 32'd0);
    endtask

    task automatic check_kind_limits();
        send_request(KIND_ACTIVE, 32'd11160);
        send_request(KIND_ACTIVE, 32'd11161);
        send_request(KIND_ACTIVE, 32'hFFFF_FFFF);
        send_request(KIND_TAU, 32'd2592000);
        send_request(KIND_TAU, 32'd2592001);
        send_request(KIND_TAU, 32'hFFFF_FFFF);
        send_request(KIND_RAU, 32'hFFFF_FFFF);
        send_request(KIND_READY, 32'hFFFF_FFFF);
    endtask

    task automatic check_unit_ties();
        send_request(KIND_RAU, 32'd600);
        send_request(KIND_RAU, 32'd60);
        send_request(KIND_READY, 32'd60);
        send_request(KIND_TAU, 32'd1152000);
        send_request(KIND_RAU, 32'd3600);
        send_request(KIND_ACTIVE, 32'd720);
    endtask

    task automatic check_no_fit();
        send_request(KIND_RAU, 32'd1);
        send_request(KIND_READY, 32'd1);
        send_request(KIND_READY, 32'd11520);
        send_request(KIND_RAU, 32'd1152000);
        send_request(KIND_TAU, 32'd1);
    endtask

    function automatic logic [31:0] pick_seconds(input logic [1:0] kind);
        longint unsigned unit_len;
        longint unsigned secs;
        int              top_code;
        secs = 0;
        case ($urandom_range(9))
            0: secs = 64'($urandom);
            1: secs = 64'($urandom >> $urandom_range(31));
            2, 3, 4, 5:
            begin
                // count times unit, near or on an exact multiple
                top_code = (kind == KIND_READY || kind == KIND_ACTIVE) ? 2 :
                           (kind == KIND_TAU) ? 6 : 5;
                unit_len = unit_secs(kind, 3'($urandom_range(top_code)));
                secs = unit_len * 64'($urandom_range(1, 33));
                if ($urandom_range(1))
                    secs = secs + 64'($urandom_range(32'(unit_len - 64'd1)));
            end
            6:
            begin
                secs = (kind == KIND_ACTIVE) ? 64'(ACTIVE_MAX_SECS) : 64'(TAU_MAX_SECS);
                secs = secs + 64'($urandom_range(4)) - 64'd2;
            end
            7: secs = 64'($urandom_range(1, 2700000));
            8: secs = 64'($urandom_range(0, 100));
            default: secs = 64'($urandom_range(1, 12000));
        endcase
        return secs[31:0];
    endfunction

    task automatic run_random_mix(input int n_items);
        logic [1:0] kind;
        for (int i = 0; i < n_items; i++)
        begin
            kind = 2'($urandom_range(3));
            send_request(kind, pick_seconds(kind));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        src_idle_pct = 12;
        sink_idle_pct = 48;
        check_deactivate();
        check_kind_limits();
        check_unit_ties();
        check_no_fit();
        run_random_mix(230);

        src_idle_pct = 48;
        sink_idle_pct = 12;
        run_random_mix(230);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        run_random_mix(240);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_codes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
